// ----- hdl/utd_pkg.sv -----
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types, constants and helpers for the utf-8 to ucs-2 decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int COUNT_W = 3;
    localparam int CONT_W  = 6;

    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic              valid;
        logic [UNIT_W-1:0] unit;
        logic              bad;
    } utd_result_t;

    // number of consecutive one bits directly below the top bit
    function automatic logic [COUNT_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
        logic [COUNT_W-1:0] cnt;
        logic               run;
        cnt = '0;
        run = 1'b1;
        for (int i = BYTE_W - 2; i >= 0; i--)
        begin
            run = run & b[i];
            if (run)
            begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt;
    endfunction

endpackage

// ----- hdl/utd_in_stage.sv -----
// ----------------------------------------------------------------------------
// utd_in_stage
// Input register for incoming byte requests.
// ----------------------------------------------------------------------------
module utd_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [utd_pkg::BYTE_W-1:0]  s_axis_tdata,
    input  logic                        s_axis_tlast,
    input  logic                        advance,
    output logic                        byte_valid,
    output logic [utd_pkg::BYTE_W-1:0]  byte_data,
    output logic                        byte_last
);
    import utd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic              take;

    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;
    assign byte_last  = last_reg;

endmodule

// ----- hdl/utd_decode.sv -----
// ----------------------------------------------------------------------------
// utd_decode
// Sequence state and the per-byte decode step.
// ----------------------------------------------------------------------------
module utd_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [utd_pkg::BYTE_W-1:0] byte_data,
    input  logic                       byte_last,
    output utd_pkg::utd_result_t       result
);
    import utd_pkg::*;

    logic [COUNT_W-1:0] bytes_left_reg;
    logic [COUNT_W-1:0] bytes_left_next;
    logic [UNIT_W-1:0]  value_acc_reg;
    logic [UNIT_W-1:0]  value_acc_next;

    logic [COUNT_W-1:0] count;
    logic [BYTE_W-2:0]  lead_payload;
    logic [UNIT_W-1:0]  shifted_acc;
    logic [COUNT_W-1:0] left_dec;

    assign count        = lead_ones(byte_data);
    assign lead_payload = byte_data[BYTE_W-2:0] & ({(BYTE_W-1){1'b1}} >> count);
    assign shifted_acc  = {value_acc_reg[UNIT_W-CONT_W-1:0], byte_data[CONT_W-1:0]};
    assign left_dec     = bytes_left_reg - 1'b1;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        value_acc_next  = value_acc_reg;
        result          = '0;
        if (bytes_left_reg == '0)
        begin
            if (!byte_data[BYTE_W-1])
            begin
                result.valid = 1'b1;
                result.unit  = {{(UNIT_W-BYTE_W){1'b0}}, byte_data};
            end
            else if (count == '0 || byte_last)
            begin
                // stray continuation, or a lead on the final byte
                result.valid    = 1'b1;
                result.bad      = 1'b1;
                bytes_left_next = '0;
                value_acc_next  = '0;
            end
            else
            begin
                value_acc_next  = {{(UNIT_W-BYTE_W+1){1'b0}}, lead_payload};
                bytes_left_next = count;
            end
        end
        else if (byte_data[BYTE_W-1:BYTE_W-2] != CONT_TAG)
        begin
            result.valid    = 1'b1;
            result.bad      = 1'b1;
            bytes_left_next = '0;
            value_acc_next  = '0;
        end
        else if (left_dec == '0)
        begin
            result.valid    = 1'b1;
            result.unit     = shifted_acc;
            bytes_left_next = '0;
            value_acc_next  = '0;
        end
        else if (byte_last)
        begin
            // text ends in mid-sequence
            result.valid    = 1'b1;
            result.bad      = 1'b1;
            bytes_left_next = '0;
            value_acc_next  = '0;
        end
        else
        begin
            bytes_left_next = left_dec;
            value_acc_next  = shifted_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            value_acc_reg  <= '0;
        end
        else if (advance)
        begin
            bytes_left_reg <= bytes_left_next;
            value_acc_reg  <= value_acc_next;
        end
    end

`ifndef SYNTHESIS
    a_result_ends_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.valid |=> bytes_left_reg == '0)
        else $error("state not back at lead byte after a result");

    a_error_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.bad |-> result.valid && result.unit == '0)
        else $error("error result carries a nonzero code unit");

    a_ascii_passes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && bytes_left_reg == '0 && !byte_data[BYTE_W-1]
            |-> result.valid && !result.bad)
        else $error("single-byte character gave no clean result");

    a_acc_cleared_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) && $past(result.valid) |-> value_acc_reg == '0)
        else $error("accumulator not cleared after a result");
`endif

endmodule

// ----- hdl/utd_out_stage.sv -----
// ----------------------------------------------------------------------------
// utd_out_stage
// Result register driving the output stream.
// ----------------------------------------------------------------------------
module utd_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    input  utd_pkg::utd_result_t        result,
    output logic                        advance,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [utd_pkg::UNIT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tuser
);
    import utd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [UNIT_W-1:0] unit_reg;
    logic              bad_reg;
    logic              load;

    assign advance = byte_valid && (!valid_reg || m_axis_tready);
    assign load    = advance && result.valid;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= result.unit;
            bad_reg  <= result.bad;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = unit_reg;
    assign m_axis_tuser  = bad_reg;

endmodule

// ----- hdl/utf8_to_ucs2_decoder_core.sv -----
// Decodes a utf-8 byte stream into 16-bit code units, one byte request per clock
// sustained while m_axis_tready does not hold back a full result register; a result
// passes through the input register, the single decode step and the result register.
// Bytes of a multi-byte sequence give no result until the sequence completes;
// malformed or truncated sequences give one result with bad_sequence set and
// a zero code unit. Code points above 16 bits are cut to their low 16 bits.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_core
// Top level: input register, decode step with sequence state, result register.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [utd_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic                        s_axis_tlast,   // end_of_text
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [utd_pkg::UNIT_W-1:0]  m_axis_tdata,   // [15:0] code_unit
    output logic                        m_axis_tuser    // [0] bad_sequence
);
    import utd_pkg::*;

    logic              advance;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              byte_last;
    utd_result_t       result;

    utd_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data),
        .byte_last     (byte_last)
    );

    utd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_data (byte_data),
        .byte_last (byte_last),
        .result    (result)
    );

    utd_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .result        (result),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
